### hdl/sha512_pkg.sv
// sha-512 package: constants, types and message schedule functions
`default_nettype none
package sha512_pkg;

    localparam int unsigned WordW = 64;

    typedef logic [63:0] t_word;

    // round constants
    localparam logic [63:0] RoundConst [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // initial hash value
    localparam logic [63:0] InitHash [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // compression control request from sequencer
    typedef struct packed {
        logic       start;  // load working vars from chain
        logic       step;   // run one round
        logic       fold;   // add working vars into chain
        logic       init;   // restore initial value
        logic [6:0] round;  // round index 0..79
    } t_core_ctl;

    function automatic t_word rotr(input t_word v, input int unsigned k);
        rotr = (v >> k) | (v << (WordW - k));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage
`default_nettype wire

### hdl/sha512_sched.sv
// sha-512 message schedule: 16-word window, one new word per round
`default_nettype none
module sha512_sched
    import sha512_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_load,
    input  wire logic [3:0]  i_load_idx,
    input  wire logic [63:0] i_load_word,
    input  wire logic        i_shift,
    output logic      [63:0] o_w
);

    logic [63:0] r_win [16];
    logic [63:0] n_new;

    // next schedule word
    assign n_new = r_win[0] + sig0(r_win[1]) + r_win[9] + sig1(r_win[14]);
    assign o_w   = r_win[0];

    // window: loaded by word, shifted once per round
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win[i_load_idx] <= i_load_word;
        end else if (i_shift) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= n_new;
        end
    end

endmodule
`default_nettype wire

### hdl/sha512_round.sv
// sha-512 round unit with working variables and chaining value
`default_nettype none
module sha512_round
    import sha512_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_core_ctl   i_ctl,
    input  wire logic [63:0] i_w,
    input  wire logic [2:0]  i_rd_idx,
    output logic      [63:0] o_rd_word
);

    logic [63:0] r_h [8];
    logic [63:0] r_a [8];
    logic [63:0] n_e1, n_ch, n_t1, n_e0, n_mj;

    // one round of the compression function
    always_comb begin
        n_e1 = rotr(r_a[4], 14) ^ rotr(r_a[4], 18) ^ rotr(r_a[4], 41);
        n_ch = (r_a[4] & r_a[5]) ^ (~r_a[4] & r_a[6]);
        n_t1 = r_a[7] + n_e1 + n_ch + RoundConst[i_ctl.round] + i_w;
        n_e0 = rotr(r_a[0], 28) ^ rotr(r_a[0], 34) ^ rotr(r_a[0], 39);
        n_mj = (r_a[0] & r_a[1]) ^ (r_a[0] & r_a[2]) ^ (r_a[1] & r_a[2]);
    end

    assign o_rd_word = r_h[i_rd_idx];

    // chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_a[i];
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) r_a[i] <= r_h[i];
        end else if (i_ctl.step) begin
            r_a[7] <= r_a[6];
            r_a[6] <= r_a[5];
            r_a[5] <= r_a[4];
            r_a[4] <= r_a[3] + n_t1;
            r_a[3] <= r_a[2];
            r_a[2] <= r_a[1];
            r_a[1] <= r_a[0];
            r_a[0] <= n_t1 + n_e0 + n_mj;
        end
    end

endmodule
`default_nettype wire

### hdl/sha512_message_hasher.sv
// sha-512 message hasher top level: word packer, padding sequencer, digest output
//
// channel  dir  tdata                                   tuser / tlast
// s_axis   in   [63:0] message_word, [67:64] valid_bytes  tlast = final_word
// m_axis   out  [63:0] digest_word                        tuser = digest_index, tlast = done
//
// a non-final word is only written into the schedule window, or, when it completes a 128-byte
// block, also runs that block (start, 80 rounds of the shared round unit, fold).
// a final word in slot k is followed by pad slots k+1 to 15 and its block, and one more
// padded block when the 0x80 marker lands in slot 14 or 15 or in the next block,
// then shows eight digest words, one per accepted output request.
// no new request is taken while padding, while a block runs or while the digest drains.
// reset is synchronous, active low, and restores the initial hash value.
`default_nettype none
module sha512_message_hasher
    import sha512_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // message_word[63:0], valid_bytes[67:64], zero
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,   // digest_word[63:0]
    output logic      [2:0]  m_axis_tuser,   // digest_index[2:0]
    output logic             m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_START, S_ROUND, S_FOLD, S_OUT
    } t_state;

    t_state      r_state;
    logic [3:0]  r_widx;        // next word slot in block
    logic [63:0] r_total;       // message bytes
    logic        r_padding;     // running the final blocks
    logic        r_pad_mark;    // 0x80 already placed
    logic        r_mark_late;   // 0x80 in slot 14, length goes in the next block
    logic        r_len_in;      // length written into the current block
    logic [6:0]  r_round;
    logic [2:0]  r_oidx;

    logic        n_load;
    logic [63:0] n_load_word;
    logic [3:0]  n_nb;
    logic [63:0] n_mask, n_tot;
    logic [63:0] n_w;
    t_core_ctl   n_ctl;
    logic        n_acc;

    assign s_axis_tready = (r_state == S_IDLE);
    assign n_acc = s_axis_tvalid && s_axis_tready;
    assign n_nb  = !s_axis_tlast ? 4'd8 :
                   (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
    assign n_tot = r_total + {60'd0, n_nb};

    // byte mask and word to write into the schedule window
    always_comb begin
        n_mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n_nb) n_mask[63-8*i -: 8] = 8'hff;
        end
        n_load = 1'b0;
        n_load_word = '0;
        if (r_state == S_IDLE && n_acc) begin
            n_load = 1'b1;
            n_load_word = s_axis_tdata[63:0] & n_mask;
            if (s_axis_tlast && n_nb != 4'd8)
                n_load_word[63-8*n_nb -: 8] = 8'h80;
        end else if (r_state == S_PAD) begin
            n_load = 1'b1;
            if (!r_pad_mark)
                n_load_word = 64'h8000_0000_0000_0000;
            else if (r_widx == 4'd14)
                n_load_word = {61'd0, r_total[63:61]};
            else if (r_widx == 4'd15 && !r_mark_late)
                n_load_word = {r_total[60:0], 3'd0};
        end
    end

    // round unit control
    always_comb begin
        n_ctl       = '0;
        n_ctl.round = r_round;
        n_ctl.start = (r_state == S_START);
        n_ctl.step  = (r_state == S_ROUND);
        n_ctl.fold  = (r_state == S_FOLD);
        n_ctl.init  = (r_state == S_OUT) && m_axis_tready && (r_oidx == 3'd7);
    end

    sha512_sched u_sched (
        .i_clk       (i_clk),
        .i_load      (n_load),
        .i_load_idx  (r_widx),
        .i_load_word (n_load_word),
        .i_shift     (r_state == S_ROUND),
        .o_w         (n_w)
    );

    sha512_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (n_ctl),
        .i_w       (n_w),
        .i_rd_idx  (r_oidx),
        .o_rd_word (m_axis_tdata)
    );

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'd7);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_total     <= '0;
            r_padding   <= 1'b0;
            r_pad_mark  <= 1'b0;
            r_mark_late <= 1'b0;
            r_round     <= '0;
            r_oidx      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (n_acc) begin
                        r_total     <= n_tot;
                        r_widx      <= r_widx + 4'd1;
                        r_padding   <= s_axis_tlast;
                        r_pad_mark  <= s_axis_tlast && (n_nb != 4'd8);
                        r_mark_late <= s_axis_tlast && (n_nb != 4'd8) && (r_widx == 4'd14);
                        if (r_widx == 4'd15) begin
                            r_state <= S_START;
                        end else if (s_axis_tlast) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    // 0x80, zero fill; length in last two slots unless marker sits there
                    r_pad_mark <= 1'b1;
                    r_widx     <= r_widx + 4'd1;
                    if (!r_pad_mark && r_widx == 4'd14) r_mark_late <= 1'b1;
                    if (r_widx == 4'd15) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_round     <= '0;
                    r_mark_late <= 1'b0;
                    r_state     <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'd79) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    if (!r_padding) begin
                        r_state <= S_IDLE;
                    end else if (r_len_in) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_state   <= S_IDLE;
                            r_total   <= '0;
                            r_padding <= 1'b0;
                            r_pad_mark <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // length written once the last slot of a length-carrying block was filled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state == S_OUT) begin
            r_len_in <= 1'b0;
        end else if (r_state == S_PAD && r_pad_mark && !r_mark_late && r_widx == 4'd15) begin
            r_len_in <= 1'b1;
        end
    end

endmodule
`default_nettype wire

### hdl/sha512_checker.sv
// port-level checker for the sha-512 hasher
`default_nettype none
module sha512_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [2:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input taken during digest");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast not on word seven");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest index skipped");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tuser == 3'd0))
        else $error("digest not starting at word zero");

endmodule

bind sha512_message_hasher sha512_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
